// ===== hw/rtl/gyro_step_counter_macros.svh =====
// Assertion macros for the gyro step counter.
`ifndef GYRO_STEP_COUNTER_MACROS_SVH
`define GYRO_STEP_COUNTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsc_pkg.sv =====
`default_nettype none

package gsc_pkg;

    localparam int NUM_AXES  = 3;
    localparam int N_AVG     = 10;   // readings per average
    localparam int RATE_W    = 16;
    localparam int SUM_W     = 21;
    localparam int CNT_W     = 6;
    localparam int VAR_W     = 16;
    localparam int PERIOD_W  = 8;
    localparam int VOTE_W    = 8;
    localparam int STEP_W    = 32;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Reciprocal for the divide by N_AVG; exact for every sum magnitude up to 2**20.
    localparam int DIV_SHIFT = 28;
    localparam int RECIP_W   = 29;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((2 ** DIV_SHIFT + N_AVG - 1) / N_AVG);

    localparam logic [VAR_W-1:0]    MIN_VAR_RESET  = VAR_W'(500);
    localparam logic [VAR_W-1:0]    MAX_VAR_RESET  = VAR_W'(5000);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(30);
    localparam logic [VOTE_W-1:0]   VOTE_MAX       = '1;

    typedef logic signed [RATE_W-1:0] rate_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_NONE,
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    localparam axis_t AXIS_CODE [NUM_AXES] = '{AXIS_X, AXIS_Y, AXIS_Z};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VARIATION,
        CFG_MAX_VARIATION,
        CFG_AXIS_PERIOD
    } cfg_index_t;

    typedef struct packed {
        logic [VAR_W-1:0]    min_variation;
        logic [VAR_W-1:0]    max_variation;
        logic [PERIOD_W-1:0] axis_period;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gsc_rate_if.sv =====
`default_nettype none

interface gsc_rate_if
    import gsc_pkg::*;
();
    logic  valid;
    logic  ready;
    rate_t rate_x;
    rate_t rate_y;
    rate_t rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gsc_result_if.sv =====
`default_nettype none

interface gsc_result_if
    import gsc_pkg::*;
();
    logic              valid;
    logic              ready;
    rate_t             accepted_x;
    rate_t             accepted_y;
    rate_t             accepted_z;
    logic [AXIS_W-1:0] active_axis;
    logic              step_seen;
    logic [STEP_W-1:0] step_total;

    modport source (
        output valid, output accepted_x, output accepted_y, output accepted_z,
        output active_axis, output step_seen, output step_total, input ready
    );
    modport sink (
        input valid, input accepted_x, input accepted_y, input accepted_z,
        input active_axis, input step_seen, input step_total, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/gsc_avg.sv =====
`default_nettype none

module gsc_avg
    import gsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire rate_t rate_x,
    input  wire rate_t rate_y,
    input  wire rate_t rate_z,
    input  wire logic out_free,
    output logic      avg_vld,
    output rate_t     avg [NUM_AXES]
);

    logic                    a_vld_reg;
    rate_t                   a_rate_reg [NUM_AXES];
    logic signed [SUM_W-1:0] sum_reg    [NUM_AXES];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    avg_vld_reg;
    rate_t                   avg_reg    [NUM_AXES];

    logic                    b_free;
    logic                    a_go;
    logic                    in_go;
    logic                    last;
    logic signed [SUM_W-1:0] sum_next   [NUM_AXES];
    logic [SUM_W-1:0]        mag        [NUM_AXES];
    logic [PROD_W-1:0]       prod       [NUM_AXES];
    logic [RATE_W:0]         quo        [NUM_AXES];
    rate_t                   avg_next   [NUM_AXES];

    // The averaging stage frees up whenever the tracking stage can hand on its beat.
    assign b_free   = !avg_vld_reg || out_free;
    assign a_go     = a_vld_reg && b_free;
    assign in_ready = !a_vld_reg || b_free;
    assign in_go    = in_valid && in_ready;
    assign last     = (cnt_reg == CNT_W'(N_AVG - 1));

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_next[a] = sum_reg[a] + SUM_W'(a_rate_reg[a]);
            mag[a]      = sum_next[a][SUM_W-1] ? SUM_W'(-sum_next[a]) : SUM_W'(sum_next[a]);
            prod[a]     = PROD_W'(mag[a]) * PROD_W'(DIV_RECIP);
            quo[a]      = prod[a][DIV_SHIFT +: RATE_W+1];
            // Negating the magnitude quotient gives truncation toward zero.
            avg_next[a] = sum_next[a][SUM_W-1] ? rate_t'(-quo[a]) : rate_t'(quo[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            avg_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            if (in_go)
            begin
                a_vld_reg <= 1'b1;
            end
            else if (a_go)
            begin
                a_vld_reg <= 1'b0;
            end

            if (a_go && last)
            begin
                avg_vld_reg <= 1'b1;
            end
            else if (out_free)
            begin
                avg_vld_reg <= 1'b0;
            end

            if (a_go)
            begin
                cnt_reg <= last ? '0 : cnt_reg + CNT_W'(1);
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sum_reg[a] <= last ? '0 : sum_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            a_rate_reg[0] <= rate_x;
            a_rate_reg[1] <= rate_y;
            a_rate_reg[2] <= rate_z;
        end
        if (a_go && last)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                avg_reg[a] <= avg_next[a];
            end
        end
    end

    assign avg_vld = avg_vld_reg;
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            avg[a] = avg_reg[a];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gsc_track.sv =====
`default_nettype none

module gsc_track
    import gsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  avg_vld,
    input  wire rate_t avg [NUM_AXES],
    output logic       out_free,
    input  wire logic  out_ready,
    output logic       out_valid,
    output rate_t      accepted [NUM_AXES],
    output axis_t      active_axis,
    output logic       step_seen,
    output logic [STEP_W-1:0] step_total
);

    rate_t              last_reg  [NUM_AXES];
    rate_t              high_reg  [NUM_AXES];
    rate_t              low_reg   [NUM_AXES];
    logic [VOTE_W-1:0]  votes_reg [NUM_AXES];
    logic [PERIOD_W-1:0] period_reg;
    axis_t              chosen_reg;
    logic [NUM_AXES-1:0] armed_reg;
    logic [STEP_W-1:0]  steps_reg;

    logic               out_vld_reg;
    rate_t              out_acc_reg [NUM_AXES];
    axis_t              out_axis_reg;
    logic               out_seen_reg;
    logic [STEP_W-1:0]  out_total_reg;

    logic                   take;
    logic signed [RATE_W:0] diff   [NUM_AXES];
    logic [RATE_W:0]        dmag   [NUM_AXES];
    logic                   reject [NUM_AXES];
    rate_t                  cur    [NUM_AXES];
    logic [RATE_W:0]        chg    [NUM_AXES];
    rate_t                  high_next [NUM_AXES];
    rate_t                  low_next  [NUM_AXES];
    logic signed [RATE_W:0] psum   [NUM_AXES];
    logic signed [RATE_W:0] padj   [NUM_AXES];
    logic signed [RATE_W:0] mid    [NUM_AXES];
    logic signed [RATE_W:0] pv     [NUM_AXES];
    logic signed [RATE_W:0] cv     [NUM_AXES];
    logic [NUM_AXES-1:0]    rise;
    logic [NUM_AXES-1:0]    fall;
    logic [NUM_AXES-1:0]    sel;
    logic [PERIOD_W:0]      period_inc;
    logic                   decide;
    axis_t                  chosen_next;
    logic [VOTE_W-1:0]      votes_base [NUM_AXES];
    logic [VOTE_W-1:0]      votes_next [NUM_AXES];
    logic [NUM_AXES-1:0]    win;
    logic [PERIOD_W-1:0]    period_next;
    logic [NUM_AXES-1:0]    armed_next;
    logic                   seen_next;
    logic [STEP_W-1:0]      steps_next;

    assign out_free = !out_vld_reg || out_ready;
    assign take     = avg_vld && out_free;

    // Plausibility filter and running extremes, one lane per axis.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff[a]   = (RATE_W+1)'(avg[a]) - (RATE_W+1)'(last_reg[a]);
            dmag[a]   = diff[a][RATE_W] ? (RATE_W+1)'(-diff[a]) : (RATE_W+1)'(diff[a]);
            reject[a] = (dmag[a] < {1'b0, cfg.min_variation})
                     || (dmag[a] > {1'b0, cfg.max_variation});
            cur[a]    = reject[a] ? last_reg[a] : avg[a];
            chg[a]    = reject[a] ? '0 : dmag[a];
            high_next[a] = (cur[a] > high_reg[a]) ? cur[a] : high_reg[a];
            low_next[a]  = (cur[a] < low_reg[a]) ? cur[a] : low_reg[a];

            // Midpoint rounded toward zero: add one to a negative sum before halving.
            psum[a] = (RATE_W+1)'(high_next[a]) + (RATE_W+1)'(low_next[a]);
            padj[a] = psum[a] + (RATE_W+1)'(psum[a][RATE_W]);
            mid[a]  = padj[a] >>> 1;
            pv[a]   = (RATE_W+1)'(last_reg[a]);
            cv[a]   = (RATE_W+1)'(cur[a]);
            rise[a] = (pv[a] < mid[a]) && (cv[a] > mid[a]);
            fall[a] = (pv[a] > mid[a]) && (cv[a] < mid[a]);
        end
    end

    // Axis decision from the votes of the closing period, then this beat's vote.
    always_comb
    begin
        period_inc = {1'b0, period_reg} + (PERIOD_W+1)'(1);
        decide     = (period_inc >= {1'b0, cfg.axis_period});
        chosen_next = chosen_reg;
        if (decide)
        begin
            if (votes_reg[0] > votes_reg[1] && votes_reg[0] > votes_reg[2])
            begin
                chosen_next = AXIS_X;
            end
            else if (votes_reg[1] > votes_reg[0] && votes_reg[1] > votes_reg[2])
            begin
                chosen_next = AXIS_Y;
            end
            else if (votes_reg[2] > votes_reg[0] && votes_reg[2] > votes_reg[1])
            begin
                chosen_next = AXIS_Z;
            end
            else
            begin
                chosen_next = AXIS_NONE;
            end
        end
        period_next = decide ? '0 : period_inc[PERIOD_W-1:0];

        win[0] = (chg[0] > chg[1]) && (chg[0] > chg[2]);
        win[1] = (chg[1] > chg[0]) && (chg[1] > chg[2]);
        win[2] = (chg[2] > chg[0]) && (chg[2] > chg[1]);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            votes_base[a] = decide ? '0 : votes_reg[a];
            votes_next[a] = (win[a] && votes_base[a] != VOTE_MAX)
                          ? votes_base[a] + VOTE_W'(1) : votes_base[a];
        end
    end

    // Step detection on the chosen axis only.
    always_comb
    begin
        armed_next = armed_reg;
        seen_next  = 1'b0;
        steps_next = steps_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sel[a] = (chosen_next == AXIS_CODE[a]);
            if (sel[a])
            begin
                if (!armed_reg[a])
                begin
                    if (rise[a])
                    begin
                        armed_next[a] = 1'b1;
                    end
                end
                else if (fall[a])
                begin
                    armed_next[a] = 1'b0;
                    seen_next     = 1'b1;
                    steps_next    = steps_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            chosen_reg  <= AXIS_NONE;
            armed_reg   <= '0;
            steps_reg   <= '0;
            out_vld_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                last_reg[a]  <= '0;
                high_reg[a]  <= '0;
                low_reg[a]   <= '0;
                votes_reg[a] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (take)
            begin
                period_reg <= period_next;
                chosen_reg <= chosen_next;
                armed_reg  <= armed_next;
                steps_reg  <= steps_next;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    last_reg[a]  <= cur[a];
                    high_reg[a]  <= high_next[a];
                    low_reg[a]   <= low_next[a];
                    votes_reg[a] <= votes_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_axis_reg  <= chosen_next;
            out_seen_reg  <= seen_next;
            out_total_reg <= steps_next;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                out_acc_reg[a] <= cur[a];
            end
        end
    end

    assign out_valid   = out_vld_reg;
    assign active_axis = out_axis_reg;
    assign step_seen   = out_seen_reg;
    assign step_total  = out_total_reg;
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            accepted[a] = out_acc_reg[a];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gyro_step_counter.sv =====
// The tenth reading of a window passes the input, average and result registers.
// Throughput: one reading per cycle, limited only by backpressure on the result channel;
// one result per ten readings, set by the averaging counter.
// Reset (rst_n low, asynchronous): sums, filter history, peaks, votes, axis choice and
// step count clear to zero; the configuration registers return to 500, 5000 and 30.
`default_nettype none

`include "gyro_step_counter_macros.svh"

module gyro_step_counter
    import gsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VAR_W-1:0]     cfg_data,
    gsc_rate_if.sink                  readings,
    gsc_result_if.source              results
);

    cfg_t  cfg_reg;
    logic  avg_vld;
    rate_t avg      [NUM_AXES];
    logic  out_free;
    rate_t accepted [NUM_AXES];
    axis_t active_axis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_variation <= MIN_VAR_RESET;
            cfg_reg.max_variation <= MAX_VAR_RESET;
            cfg_reg.axis_period   <= PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MIN_VARIATION: cfg_reg.min_variation <= cfg_data;
                CFG_MAX_VARIATION: cfg_reg.max_variation <= cfg_data;
                CFG_AXIS_PERIOD:   cfg_reg.axis_period   <= cfg_data[PERIOD_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    gsc_avg u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (readings.valid),
        .in_ready (readings.ready),
        .rate_x   (readings.rate_x),
        .rate_y   (readings.rate_y),
        .rate_z   (readings.rate_z),
        .out_free (out_free),
        .avg_vld  (avg_vld),
        .avg      (avg)
    );

    gsc_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .avg_vld     (avg_vld),
        .avg         (avg),
        .out_free    (out_free),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .accepted    (accepted),
        .active_axis (active_axis),
        .step_seen   (results.step_seen),
        .step_total  (results.step_total)
    );

    assign results.accepted_x  = accepted[0];
    assign results.accepted_y  = accepted[1];
    assign results.accepted_z  = accepted[2];
    assign results.active_axis = active_axis;

    // Input stalls can only come from a result beat waiting on the sink.
    `GSC_ASSERT_NOW(a_stall_source, !readings.ready, results.valid && !results.ready,
        "reading channel stalled without a waiting result beat")
    // A fresh result beat must have come from a completed average.
    `GSC_ASSERT_NOW(a_result_origin, $rose(results.valid), $past(avg_vld),
        "result beat appeared without a completed average")
    // An empty result register takes a waiting average straight away.
    `GSC_ASSERT_NEXT(a_no_bubble, avg_vld && !results.valid, results.valid,
        "completed average not moved into an empty result register")
    // A counted step always belongs to a known axis.
    `GSC_ASSERT_NOW(a_step_axis, results.valid && results.step_seen,
        results.active_axis != AXIS_NONE, "step reported with no active axis")

endmodule

`default_nettype wire

// ===== tb/sv/tb_gyro_step_counter.sv =====
import gsc_pkg::*;

typedef struct {
    rate_t       x;
    rate_t       y;
    rate_t       z;
    axis_t       axis;
    logic        seen;
    logic [31:0] total;
} step_result_t;

class step_scoreboard;
    int errors;
    int results_seen;
    int min_var;
    int max_var;
    int axis_per;
    int sums[3];
    int count;
    int last[3];
    int hi[3];
    int lo[3];
    int votes[3];
    int period_cnt;
    axis_t chosen;
    bit armed[3];
    logic [31:0] steps;
    step_result_t pending_results[$];

    function new();
        errors = 0;
        results_seen = 0;
        min_var = int'(MIN_VAR_RESET);
        max_var = int'(MAX_VAR_RESET);
        axis_per = int'(PERIOD_RESET);
        count = 0;
        period_cnt = 0;
        chosen = AXIS_NONE;
        steps = '0;
        for (int a = 0; a < 3; a++) begin
            sums[a] = 0;
            last[a] = 0;
            hi[a] = 0;
            lo[a] = 0;
            votes[a] = 0;
            armed[a] = 1'b0;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void set_config(cfg_index_t idx, logic [VAR_W-1:0] v);
        case (idx)
            CFG_MIN_VARIATION: min_var = int'(v);
            CFG_MAX_VARIATION: max_var = int'(v);
            CFG_AXIS_PERIOD:   axis_per = int'(v[PERIOD_W-1:0]);
            default: ;
        endcase
    endfunction

    task flag_mismatch(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    // Accumulates one reading; every tenth one closes an average and queues a result.
    function void note_reading(rate_t rx, rate_t ry, rate_t rz);
        int in_val[3];
        int prev[3];
        int cur[3];
        int chg[3];
        int avg;
        int gap;
        int win;
        int k;
        int mid;
        step_result_t r;
        in_val[0] = rx;
        in_val[1] = ry;
        in_val[2] = rz;
        for (int a = 0; a < 3; a++)
            sums[a] += in_val[a];
        count++;
        if (count < N_AVG)
            return;
        count = 0;

        for (int a = 0; a < 3; a++)
        begin
            avg = sums[a] / N_AVG;
            sums[a] = 0;
            prev[a] = last[a];
            gap = (avg > prev[a]) ? avg - prev[a] : prev[a] - avg;
            cur[a] = (gap < min_var || gap > max_var) ? prev[a] : avg;
            last[a] = cur[a];
            if (cur[a] > hi[a])
                hi[a] = cur[a];
            if (cur[a] < lo[a])
                lo[a] = cur[a];
            chg[a] = (cur[a] > prev[a]) ? cur[a] - prev[a] : prev[a] - cur[a];
        end

        // The axis decision uses the votes gathered before this average's own vote.
        period_cnt++;
        if (period_cnt >= axis_per)
        begin
            if (votes[0] > votes[1] && votes[0] > votes[2])
                chosen = AXIS_X;
            else if (votes[1] > votes[0] && votes[1] > votes[2])
                chosen = AXIS_Y;
            else if (votes[2] > votes[0] && votes[2] > votes[1])
                chosen = AXIS_Z;
            else
                chosen = AXIS_NONE;
            period_cnt = 0;
            for (int a = 0; a < 3; a++)
                votes[a] = 0;
        end

        win = -1;
        if (chg[0] > chg[1] && chg[0] > chg[2])
            win = 0;
        else if (chg[1] > chg[0] && chg[1] > chg[2])
            win = 1;
        else if (chg[2] > chg[0] && chg[2] > chg[1])
            win = 2;
        if (win >= 0 && votes[win] < int'(VOTE_MAX))
            votes[win]++;

        r.seen = 1'b0;
        if (chosen != AXIS_NONE)
        begin
            k = int'(chosen) - 1;
            mid = (hi[k] + lo[k]) / 2;
            if (!armed[k])
            begin
                if (prev[k] < mid && cur[k] > mid)
                    armed[k] = 1'b1;
            end
            else if (prev[k] > mid && cur[k] < mid)
            begin
                steps++;
                armed[k] = 1'b0;
                r.seen = 1'b1;
            end
        end

        r.x = rate_t'(cur[0]);
        r.y = rate_t'(cur[1]);
        r.z = rate_t'(cur[2]);
        r.axis = chosen;
        r.total = steps;
        pending_results.push_back(r);
    endfunction

    task check_result(step_result_t got);
        step_result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = pending_results.pop_front();
        if (got.x !== want.x)
            flag_mismatch($sformatf("result %0d accepted_x got %0d want %0d",
                                    results_seen, got.x, want.x));
        if (got.y !== want.y)
            flag_mismatch($sformatf("result %0d accepted_y got %0d want %0d",
                                    results_seen, got.y, want.y));
        if (got.z !== want.z)
            flag_mismatch($sformatf("result %0d accepted_z got %0d want %0d",
                                    results_seen, got.z, want.z));
        if (got.axis !== want.axis)
            flag_mismatch($sformatf("result %0d active_axis got %0d want %0d",
                                    results_seen, got.axis, want.axis));
        if (got.seen !== want.seen)
            flag_mismatch($sformatf("result %0d step_seen got %0b want %0b",
                                    results_seen, got.seen, want.seen));
        if (got.total !== want.total)
            flag_mismatch($sformatf("result %0d step_total got %0d want %0d",
                                    results_seen, got.total, want.total));
    endtask
endclass

module tb_gyro_step_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        rate_t x;
        rate_t y;
        rate_t z;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAR_W-1:0]     cfg_data;

    gsc_rate_if   rd_if ();
    gsc_result_if res_if ();

    gyro_step_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .readings  (rd_if.sink),
        .results   (res_if.source)
    );

    step_scoreboard sb = new();
    reading_t stim_q[$];
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit sink_hold_req = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin : monitor
        step_result_t got;
        if (rst_n)
        begin
            if (rd_if.valid && rd_if.ready)
                sb.note_reading(rd_if.rate_x, rd_if.rate_y, rd_if.rate_z);
            if (res_if.valid && res_if.ready)
            begin
                got.x = res_if.accepted_x;
                got.y = res_if.accepted_y;
                got.z = res_if.accepted_z;
                got.axis = axis_t'(res_if.active_axis);
                got.seen = res_if.step_seen;
                got.total = res_if.step_total;
                sb.check_result(got);
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rd_if.valid && rd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic rate_t clamp_rate(int v);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return rate_t'(v);
    endfunction

    task automatic push_reading(int x, int y, int z);
        reading_t r;
        r.x = clamp_rate(x);
        r.y = clamp_rate(y);
        r.z = clamp_rate(z);
        stim_q.push_back(r);
    endtask

    // One averaging window's worth of readings scattered around the given levels.
    task automatic push_group(input int t[3], input int jit);
        int j[3];
        for (int i = 0; i < N_AVG; i++)
        begin
            for (int a = 0; a < 3; a++)
                j[a] = (jit == 0) ? 0 : int'($urandom_range(2 * jit)) - jit;
            push_reading(t[0] + j[0], t[1] + j[1], t[2] + j[2]);
        end
    endtask

    task automatic push_noise(int n);
        reading_t r;
        for (int i = 0; i < n; i++)
        begin
            r.x = rate_t'($urandom);
            r.y = rate_t'($urandom);
            r.z = rate_t'($urandom);
            stim_q.push_back(r);
        end
    endtask

    task automatic drive_readings();
        reading_t r;
        while (stim_q.size() > 0)
        begin
            r = stim_q.pop_front();
            while ($urandom_range(99) < src_idle_pct)
            begin
                rd_if.valid <= 1'b0;
                @(posedge clk);
            end
            rd_if.valid <= 1'b1;
            rd_if.rate_x <= r.x;
            rd_if.rate_y <= r.y;
            rd_if.rate_z <= r.z;
            @(posedge clk);
            while (!rd_if.ready)
                @(posedge clk);
        end
        rd_if.valid <= 1'b0;
    endtask

    // A partial window leaves nothing in flight, so a short margin past the latency will do.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(int mn, int mx, int per);
        cfg_index_t order[3] = '{CFG_MIN_VARIATION, CFG_MAX_VARIATION, CFG_AXIS_PERIOD};
        logic [VAR_W-1:0] vals[3];
        vals[0] = VAR_W'(mn);
        vals[1] = VAR_W'(mx);
        // Upper bits of the period beat carry junk that the register must drop.
        vals[2] = {8'($urandom), PERIOD_W'(per)};
        for (int i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_config(order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly one axis swinging between two levels inside the variation window, so that
    // the axis gets chosen and steps are counted; the rest is noise and broken windows.
    task automatic random_phase(int mn, int mx, int per, int groups,
                                int src_pct, int snk_pct, bit long_hold);
        int tgt[3];
        int ext[3];
        int dom;
        int sgn;
        int amp;
        int lo_sw;
        int hi_sw;
        int roll;
        configure(mn, mx, per);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        lo_sw = mn + 10;
        hi_sw = mx / 2 - 10;
        if (hi_sw > 16000)
            hi_sw = 16000;
        if (lo_sw <= hi_sw)
            amp = $urandom_range(hi_sw, lo_sw);
        else
            amp = $urandom_range(16000, 100);
        dom = $urandom_range(2);
        sgn = 1;
        for (int a = 0; a < 3; a++)
            tgt[a] = int'($urandom_range(600)) - 300;

        for (int g = 0; g < groups; g++)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
                push_noise(N_AVG);
            else if (roll < 17)
                push_noise($urandom_range(15, 1));
            else if (roll < 22)
            begin
                for (int a = 0; a < 3; a++)
                    case ($urandom_range(2))
                        0: ext[a] = -32768;
                        1: ext[a] = 32767;
                        default: ext[a] = 0;
                    endcase
                push_group(ext, 0);
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    dom = $urandom_range(2);
                sgn = -sgn;
                if ($urandom_range(4) == 0)
                    tgt[dom] = int'($urandom_range(2 * amp)) - amp;
                else
                    tgt[dom] = sgn * amp;
                push_group(tgt, 40);
            end
        end

        if (long_hold)
            sink_hold_req = 1'b1;
        drive_readings();
        wait_drained();
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MIN_VARIATION;
        cfg_data = '0;
        rd_if.valid = 1'b0;
        rd_if.rate_x = '0;
        rd_if.rate_y = '0;
        rd_if.rate_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: X far above the window, Y exactly at the lower bound,
        // Z one above the upper bound.
        src_idle_pct = 30;
        snk_idle_pct = 50;
        push_group('{32767, 500, 5001}, 0);
        drive_readings();
        wait_drained();

        // Widest window, decision on every average. Y checks truncation toward zero,
        // then X and Z jump across the full range with a tie on the change.
        configure(0, 65535, 1);
        for (int i = 0; i < N_AVG; i++)
            push_reading(-32768, (i == 0) ? -1 : -2, 32767);
        for (int i = 0; i < N_AVG; i++)
            push_reading(32767, (i == 0) ? 1 : 2, -32768);
        drive_readings();
        wait_drained();

        random_phase(200, 9000, 3, 12, 30, 50, 1'b0);
        random_phase(0, 65535, 1, 12, 30, 50, 1'b0);
        // Inverted window with a zero period: nothing gets through.
        random_phase(65535, 0, 0, 6, 50, 30, 1'b0);
        random_phase(1000, 30000, 5, 16, 50, 30, 1'b1);
        random_phase(0, 0, 255, 6, 0, 0, 1'b0);
        random_phase(500, 5000, 2, 14, 0, 0, 1'b0);

        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
